// ----- src/plie_pkg.sv -----
// ----------------------------------------------------------------------------
// plie_pkg: shared types for the positional insert/erase list
// Operation and status codes and the command broadcast to the row of cells.
// ----------------------------------------------------------------------------
package plie_pkg;

  localparam int WordW  = 32;
  localparam int PosW   = 6;
  localparam int OpW    = 3;
  localparam int StatW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What every cell does in the cycle of a transfer.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,  // cell at pos takes the word, cells above take the left neighbor
    CELL_SHIFT = 2'd2   // cells at pos and above take the right neighbor
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [WordW-1:0]   value;
  } cell_cmd_t;

endpackage

// ----- src/positional_insert_erase_list.sv -----
// ----------------------------------------------------------------------------
// positional_insert_erase_list: bounded ordered list of signed words
// A row of cells holds the entries and shifts them all at once on insert
// and erase; every transfer in gives one result transfer out.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                              tuser
//  s_*      in   position[5:0], value[37:6]         operation[2:0]
//  m_*      out  read_word[31:0], entry_count[37:32] status[1:0]
//
// One item per cycle: the whole row of cells updates in the cycle of the
// input transfer and the result sits in the output register the cycle after.
// The output register sets the rate; s_tready is high while it is empty or
// being drained, so a stalled m_tready stops input after one held result.
// Reset clears the count and the output valid; entries are not cleared and
// no clearing pass is run.
module positional_insert_erase_list #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[5:0], value[37:6], zero fill
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_word[31:0], entry_count[37:32], zero fill
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > plie_pkg::PosW) ? CW : plie_pkg::PosW;
  localparam logic [CMPW-1:0] Cap = CMPW'(CAPACITY);

  logic [CW-1:0]               cnt;
  logic [CW-1:0]               cnt_next;
  logic [CMPW-1:0]             cnt_ext;
  logic [CMPW-1:0]             pos_ext;
  logic [CMPW-1:0]             cell_pos;
  logic                        s_acc;
  logic                        full;
  logic                        empty;
  plie_pkg::op_t               op;
  plie_pkg::status_t           status_next;
  plie_pkg::cell_cmd_t         cmd;
  logic                        rd_sel;
  logic [plie_pkg::WordW-1:0]  rd_any;
  logic [plie_pkg::WordW-1:0]  in_value;

  logic [plie_pkg::WordW-1:0]  entry   [CAPACITY];
  logic [plie_pkg::WordW-1:0]  rd_word [CAPACITY];

  logic [plie_pkg::WordW-1:0]  read_word;
  logic [CMPW-1:0]             out_cnt;
  plie_pkg::status_t           status;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign op       = plie_pkg::op_t'(s_tuser);
  assign in_value = s_tdata[37:6];
  assign pos_ext  = CMPW'(s_tdata[5:0]);
  assign cnt_ext  = CMPW'(cnt);
  assign full     = (cnt_ext >= Cap);
  assign empty    = (cnt == '0);

  // Decode the operation into a cell command, the new count and the status.
  always_comb begin
    cmd.op      = plie_pkg::CELL_HOLD;
    cmd.value   = in_value;
    cell_pos    = pos_ext;
    cnt_next    = cnt;
    status_next = plie_pkg::ST_OK;
    rd_sel      = 1'b0;
    unique case (op)
      plie_pkg::OP_APPEND: begin
        cell_pos = cnt_ext;
        if (full) begin
          status_next = plie_pkg::ST_FULL;
        end else begin
          cmd.op   = plie_pkg::CELL_LOAD;
          cnt_next = cnt + CW'(1);
        end
      end
      plie_pkg::OP_REMOVE: begin
        if (empty) begin
          status_next = plie_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      plie_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = plie_pkg::ST_RANGE;
        end else if (full) begin
          status_next = plie_pkg::ST_FULL;
        end else begin
          cmd.op   = plie_pkg::CELL_LOAD;
          cnt_next = cnt + CW'(1);
        end
      end
      plie_pkg::OP_ERASE: begin
        if (empty) begin
          status_next = plie_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = plie_pkg::ST_RANGE;
        end else begin
          cmd.op   = plie_pkg::CELL_SHIFT;
          cnt_next = cnt - CW'(1);
        end
      end
      plie_pkg::OP_READ: begin
        if (empty) begin
          status_next = plie_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = plie_pkg::ST_RANGE;
        end else begin
          rd_sel = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (!s_acc) begin
      cmd.op = plie_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [plie_pkg::WordW-1:0] left;
    logic [plie_pkg::WordW-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[i-1];
    end
    // The top cell has no right neighbor and takes zero on erase.
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[i+1];
    end
    plie_cell #(
      .INDEX (i),
      .PW    (CMPW)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pos     (cell_pos),
      .left    (left),
      .right   (right),
      .entry   (entry[i]),
      .rd_word (rd_word[i])
    );
  end

  // At most one cell matches the position, so the read bus is an OR.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | rd_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_acc) begin
        cnt      <= cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      read_word <= rd_sel ? rd_any : '0;
      out_cnt   <= CMPW'(cnt_next);
      status    <= status_next;
    end
  end

  assign m_tdata = {2'b00, out_cnt[5:0], read_word};
  assign m_tuser = status;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= Cap)
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> (cnt == $past(cnt)) || (cnt == $past(cnt) + CW'(1)) ||
              (cnt == $past(cnt) - CW'(1)))
    else $error("entry count moved by more than one");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == plie_pkg::ST_FULL) |-> out_cnt == Cap)
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == plie_pkg::ST_EMPTY) |-> out_cnt == '0)
    else $error("empty status with entries held");

  a_word_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status != plie_pkg::ST_OK) |-> read_word == '0)
    else $error("read word driven on failed operation");

endmodule

// ----- src/plie_cell.sv -----
// ----------------------------------------------------------------------------
// plie_cell: one entry of the list
// Holds one word, loads it, or takes it from a neighbor, and drives it onto
// the read bus when its index matches the position.
// ----------------------------------------------------------------------------
module plie_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 6
) (
  input  logic                          clk,
  input  plie_pkg::cell_cmd_t           cmd,
  input  logic [PW-1:0]                 pos,
  input  logic [plie_pkg::WordW-1:0]    left,
  input  logic [plie_pkg::WordW-1:0]    right,
  output logic [plie_pkg::WordW-1:0]    entry,
  output logic [plie_pkg::WordW-1:0]    rd_word
);

  localparam logic [PW-1:0] Idx = PW'(INDEX);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      plie_pkg::CELL_LOAD: begin
        if (Idx == pos) begin
          entry <= cmd.value;
        end else if (Idx > pos) begin
          entry <= left;
        end
      end
      plie_pkg::CELL_SHIFT: begin
        if (Idx >= pos) begin
          entry <= right;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_word = (Idx == pos) ? entry : '0;

endmodule

// ----- bench/positional_insert_erase_list_test.sv -----
// ----------------------------------------------------------------------------
// positional_insert_erase_list_test: self-checking bench for the list block
// Drives append, remove, insert, erase, read and unused operation codes with
// random gaps on both streams. A shadow copy of the list predicts every reply,
// and each reply is checked field by field in order.
// ----------------------------------------------------------------------------
module positional_insert_erase_list_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 630;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIX    = 2;

  // Codes past the last defined operation; the block answers them without change.
  localparam logic [plie_pkg::OpW-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [plie_pkg::OpW-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [plie_pkg::WordW-1:0] word;
    logic [plie_pkg::PosW-1:0]  count;
    plie_pkg::status_t          status;
  } list_reply_t;

  // Shadow of the list contents; one reply predicted per accepted command.
  class list_shadow;
    logic [plie_pkg::WordW-1:0] cells [CAPACITY];
    int unsigned      count;
    list_reply_t      replies [$];
    int               errors;
    int               commands;
    int               checked;
    int               status_hits [4];
    int unsigned      peak;

    function new();
      count    = 0;
      errors   = 0;
      commands = 0;
      checked  = 0;
      peak     = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void note_command(logic [plie_pkg::OpW-1:0] op, logic [plie_pkg::PosW-1:0] pos,
                               logic [plie_pkg::WordW-1:0] val);
      list_reply_t r;
      r.word   = '0;
      r.status = plie_pkg::ST_OK;
      case (op)
        plie_pkg::OP_APPEND: begin
          if (count >= CAPACITY) begin
            r.status = plie_pkg::ST_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        plie_pkg::OP_REMOVE: begin
          if (count == 0) begin
            r.status = plie_pkg::ST_EMPTY;
          end else begin
            cells[count-1] = '0;
            count--;
          end
        end
        plie_pkg::OP_INSERT: begin
          // The range check wins over the full check.
          if (pos > count) begin
            r.status = plie_pkg::ST_RANGE;
          end else if (count >= CAPACITY) begin
            r.status = plie_pkg::ST_FULL;
          end else begin
            for (int i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            count++;
          end
        end
        plie_pkg::OP_ERASE: begin
          if (count == 0) begin
            r.status = plie_pkg::ST_EMPTY;
          end else if (pos >= count) begin
            r.status = plie_pkg::ST_RANGE;
          end else begin
            for (int i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            cells[count-1] = '0;
            count--;
          end
        end
        plie_pkg::OP_READ: begin
          if (count == 0) begin
            r.status = plie_pkg::ST_EMPTY;
          end else if (pos >= count) begin
            r.status = plie_pkg::ST_RANGE;
          end else begin
            r.word = cells[pos];
          end
        end
        default: ;
      endcase
      r.count = count[plie_pkg::PosW-1:0];
      replies.insert(replies.size(), r);
      commands++;
      status_hits[r.status]++;
      if (count > peak) peak = count;
    endfunction

    function void check_reply(logic [plie_pkg::WordW-1:0] word,
                              logic [plie_pkg::PosW-1:0] cnt,
                              logic [plie_pkg::StatW-1:0] st);
      list_reply_t e;
      if (replies.size() == 0) begin
        $display("%0t: reply with nothing outstanding: word %h count %0d status %0d",
                 $time, word, cnt, st);
        errors++;
        return;
      end
      e = replies.pop_front();
      checked++;
      if (word !== e.word) begin
        $display("%0t: read_word expected %h got %h", $time, e.word, word);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, e.count, cnt);
        errors++;
      end
      if (st !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, st);
        errors++;
      end
    endfunction

    function int pending();
      return replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // position[5:0], value[37:6], zero fill
  logic [2:0]  s_tuser;   // operation[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // read_word[31:0], entry_count[37:32], zero fill
  logic [1:0]  m_tuser;   // status[1:0]

  list_shadow sb = new();
  bit         steady;
  int         idle_cycles;

  positional_insert_erase_list #(.CAPACITY(CAPACITY)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none during a steady stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic logic [plie_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [plie_pkg::OpW-1:0] pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_GROW) begin
      if (r < 35) return plie_pkg::OP_APPEND;
      if (r < 65) return plie_pkg::OP_INSERT;
      if (r < 85) return plie_pkg::OP_READ;
      if (r < 90) return plie_pkg::OP_ERASE;
      if (r < 95) return plie_pkg::OP_REMOVE;
    end else if (mode == MODE_SHRINK) begin
      if (r < 25) return plie_pkg::OP_REMOVE;
      if (r < 60) return plie_pkg::OP_ERASE;
      if (r < 85) return plie_pkg::OP_READ;
      if (r < 90) return plie_pkg::OP_APPEND;
      if (r < 95) return plie_pkg::OP_INSERT;
    end else begin
      if (r < 18) return plie_pkg::OP_APPEND;
      if (r < 36) return plie_pkg::OP_REMOVE;
      if (r < 54) return plie_pkg::OP_INSERT;
      if (r < 72) return plie_pkg::OP_ERASE;
      if (r < 95) return plie_pkg::OP_READ;
    end
    return plie_pkg::OpW'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  // Mostly positions that hit a live entry, plus the boundary and stray ones.
  function automatic logic [plie_pkg::PosW-1:0] pick_pos(logic [plie_pkg::OpW-1:0] op);
    int unsigned n;
    int          r;
    n = sb.count;
    r = $urandom_range(0, 99);
    if (r < 15) return plie_pkg::PosW'($urandom_range(0, CAPACITY));
    if (r < 30) return plie_pkg::PosW'(n);
    if (op == plie_pkg::OP_INSERT) return plie_pkg::PosW'($urandom_range(0, n));
    if (n == 0) return '0;
    return plie_pkg::PosW'($urandom_range(0, n - 1));
  endfunction

  task automatic send_item(logic [plie_pkg::OpW-1:0] op, logic [plie_pkg::PosW-1:0] pos,
                           logic [plie_pkg::WordW-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, val, pos};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_command(op, pos, val);
  endtask

  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_reply(m_tdata[31:0], m_tdata[37:32], m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d replies outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("positional_insert_erase_list verification failed");
        $finish;
      end
    end
  end

  initial begin
    int                         sent;
    int                         phase_len;
    int                         mode;
    int                         guard;
    logic [plie_pkg::OpW-1:0]   op;
    steady   = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: every operation that needs an entry must report empty; then edge cases on a short list.
    send_item(plie_pkg::OP_READ,   6'd0,  32'h1234_5678);
    send_item(plie_pkg::OP_REMOVE, 6'd0,  32'h0);
    send_item(plie_pkg::OP_ERASE,  6'd0,  32'h0);
    send_item(plie_pkg::OP_INSERT, 6'd1,  32'hdead_beef);
    send_item(plie_pkg::OP_INSERT, 6'd0,  32'h7fff_ffff);
    send_item(plie_pkg::OP_APPEND, 6'd63, 32'h8000_0000);
    send_item(plie_pkg::OP_APPEND, 6'd0,  32'hffff_ffff);
    send_item(plie_pkg::OP_INSERT, 6'd1,  32'h0000_0000);
    send_item(plie_pkg::OP_READ,   6'd0,  32'h0);
    send_item(plie_pkg::OP_READ,   6'd1,  32'h0);
    send_item(plie_pkg::OP_READ,   6'd3,  32'hffff_ffff);
    send_item(plie_pkg::OP_READ,   6'd4,  32'h0);
    send_item(plie_pkg::OP_ERASE,  6'd4,  32'h0);
    send_item(plie_pkg::OP_INSERT, 6'd5,  32'h0);
    // Inserting at the count is the same as appending.
    send_item(plie_pkg::OP_INSERT, 6'd4,  32'h5a5a_5a5a);
    send_item(plie_pkg::OP_ERASE,  6'd1,  32'h0);
    send_item(plie_pkg::OP_ERASE,  6'd0,  32'h0);
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
      send_item(c[plie_pkg::OpW-1:0], 6'd0, 32'ha5a5_a5a5);
    send_item(plie_pkg::OP_READ,   6'd32, 32'h0);
    send_item(plie_pkg::OP_REMOVE, 6'd32, 32'h0);
    send_item(plie_pkg::OP_READ,   6'd2,  32'h0);

    // Phases that fill, drain or churn the list; the first one grows it.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode      = (sent == 0) ? MODE_GROW : $urandom_range(MODE_GROW, MODE_MIX);
      steady    = ($urandom_range(0, 3) == 0);
      phase_len = (mode == MODE_GROW) ? $urandom_range(55, 80) : $urandom_range(30, 60);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        op = pick_op(mode);
        send_item(op, pick_pos(op), pick_word());
      end
      sent += phase_len;
    end
    s_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < STALL_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d replies never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Sent %0d commands and checked %0d replies; the list peaked at %0d entries.",
             sb.commands, sb.checked, sb.peak);
    $display("Replies by status: ok %0d, full %0d, out of range %0d, empty %0d.",
             sb.status_hits[plie_pkg::ST_OK], sb.status_hits[plie_pkg::ST_FULL],
             sb.status_hits[plie_pkg::ST_RANGE], sb.status_hits[plie_pkg::ST_EMPTY]);
    if (sb.errors == 0) begin
      $display("positional_insert_erase_list verification clean");
    end else begin
      $display("positional_insert_erase_list verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/plie_pkg.sv
src/plie_cell.sv
src/positional_insert_erase_list.sv
bench/positional_insert_erase_list_test.sv
